@@ rtl/sorted_list_table_defines.svh @@
// assertion macros shared by the checker of the sorted list table
// no dependencies; included by files that carry assertions
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define SLT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slt check failed");

// next-cycle implication, reset masks the check
`define SLT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slt check failed");

`endif

@@ rtl/slt_pkg.sv @@
// shared types and constants of the sorted list table
// no dependencies; imported by every module of the block
package slt_pkg;

  localparam int SLT_DEPTH       = 16;
  localparam int SLT_VALUE_WIDTH = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_REVERSE = 2'd2,
    OP_DUMP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_DONE      = 3'd0,
    STS_FULL      = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_LISTED    = 3'd3,
    STS_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_REV_A,
    S_REV_B,
    S_REV_C,
    S_DUMP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    logic    last;
  } res_ctrl_t;

endpackage

@@ rtl/slt_cmp.sv @@
// shared compare unit: signed greater-than and equality
// depends on slt_pkg for the default width
module slt_cmp
  import slt_pkg::*;
#(
  parameter int VALUE_WIDTH = SLT_VALUE_WIDTH
) (
  input  logic signed [VALUE_WIDTH-1:0] a,
  input  logic signed [VALUE_WIDTH-1:0] b,
  output logic                          gt,
  output logic                          eq
);

  assign gt = a > b;
  assign eq = a == b;

endmodule

@@ rtl/slt_seq.sv @@
// sequencer and entry memory of the sorted list table
// depends on slt_pkg and slt_cmp
module slt_seq
  import slt_pkg::*;
#(
  parameter int DEPTH       = SLT_DEPTH,
  parameter int VALUE_WIDTH = SLT_VALUE_WIDTH,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  op_t                           cmd_op,
  input  logic signed [VALUE_WIDTH-1:0] cmd_value,
  output res_ctrl_t                     res_ctrl,
  output logic signed [VALUE_WIDTH-1:0] res_value,
  output logic        [CW-1:0]          res_count,
  input  logic                          res_ready
);

  logic signed [VALUE_WIDTH-1:0] mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_data_r;
  logic        [AW-1:0]          rd_addr;
  logic                          wr_en;
  logic        [AW-1:0]          wr_addr;
  logic signed [VALUE_WIDTH-1:0] wr_data;

  state_t                        state_r, state_nxt;
  logic        [CW-1:0]          count_r, count_nxt;
  logic        [CW-1:0]          idx_r, idx_nxt;
  logic        [AW-1:0]          lo_r, lo_nxt;
  logic        [AW-1:0]          hi_r, hi_nxt;
  logic signed [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic signed [VALUE_WIDTH-1:0] tmp_r, tmp_nxt;
  logic                          flag_r, flag_nxt;
  status_t                       status_r, status_nxt;

  logic gt, eq;
  logic walk_end;
  logic rev_more;
  logic dump_last;

  slt_cmp #(.VALUE_WIDTH(VALUE_WIDTH)) u_cmp (
    .a  (rd_data_r),
    .b  (val_r),
    .gt (gt),
    .eq (eq)
  );

  assign walk_end  = idx_r == count_r;
  // another pair remains once both ends step inward
  assign rev_more  = (CW'(lo_r) + CW'(1)) < (CW'(hi_r) - CW'(1));
  assign dump_last = (idx_r + CW'(1)) == count_r;
  assign cmd_ready = state_r == S_IDLE;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_op)
            OP_INSERT:  state_nxt = (count_r == CW'(DEPTH)) ? S_RESP : S_INS;
            OP_DELETE:  state_nxt = (count_r == '0) ? S_RESP : S_DEL;
            OP_REVERSE: state_nxt = (count_r < CW'(2)) ? S_RESP : S_REV_A;
            OP_DUMP:    state_nxt = (count_r == '0) ? S_RESP : S_DUMP;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS, S_DEL: begin
        if (walk_end) state_nxt = S_RESP;
      end
      S_REV_A: state_nxt = S_REV_B;
      S_REV_B: state_nxt = S_REV_C;
      S_REV_C: state_nxt = rev_more ? S_REV_A : S_RESP;
      S_DUMP: begin
        if (res_ready && dump_last) state_nxt = S_IDLE;
      end
      S_RESP: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result outputs
  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    val_nxt    = val_r;
    tmp_nxt    = tmp_r;
    flag_nxt   = flag_r;
    status_nxt = status_r;
    rd_addr    = idx_r[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = idx_r[AW-1:0];
    wr_data    = tmp_r;
    res_ctrl   = '{valid: 1'b0, status: STS_DONE, last: 1'b0};
    res_value  = '0;
    res_count  = count_r;
    unique case (state_r)
      S_IDLE: begin
        val_nxt  = cmd_value;
        tmp_nxt  = cmd_value;
        idx_nxt  = '0;
        flag_nxt = 1'b0;
        lo_nxt   = '0;
        hi_nxt   = AW'(count_r - CW'(1));
        rd_addr  = '0;
        unique case (cmd_op)
          OP_INSERT:  status_nxt = (count_r == CW'(DEPTH)) ? STS_FULL : STS_DONE;
          OP_DELETE:  status_nxt = STS_NOT_FOUND;
          OP_REVERSE: status_nxt = STS_DONE;
          OP_DUMP:    status_nxt = STS_EMPTY;
          default:    status_nxt = STS_DONE;
        endcase
      end
      S_INS: begin
        if (walk_end) begin
          // carry holds the new value or the last entry pushed down
          wr_en      = 1'b1;
          count_nxt  = count_r + CW'(1);
          status_nxt = STS_DONE;
        end else begin
          if (flag_r || gt) begin
            wr_en    = 1'b1;
            tmp_nxt  = rd_data_r;
            flag_nxt = 1'b1;
          end
          idx_nxt = idx_r + CW'(1);
          rd_addr = idx_nxt[AW-1:0];
        end
      end
      S_DEL: begin
        if (walk_end) begin
          if (flag_r) begin
            count_nxt  = count_r - CW'(1);
            status_nxt = STS_DONE;
          end else begin
            status_nxt = STS_NOT_FOUND;
          end
        end else begin
          if (flag_r) begin
            // pull the entries behind the match up by one
            wr_en   = 1'b1;
            wr_addr = AW'(idx_r - CW'(1));
            wr_data = rd_data_r;
          end else if (eq) begin
            flag_nxt = 1'b1;
          end
          idx_nxt = idx_r + CW'(1);
          rd_addr = idx_nxt[AW-1:0];
        end
      end
      S_REV_A: begin
        tmp_nxt = rd_data_r;
        rd_addr = hi_r;
      end
      S_REV_B: begin
        wr_en   = 1'b1;
        wr_addr = lo_r;
        wr_data = rd_data_r;
      end
      S_REV_C: begin
        wr_en   = 1'b1;
        wr_addr = hi_r;
        wr_data = tmp_r;
        lo_nxt  = lo_r + AW'(1);
        hi_nxt  = hi_r - AW'(1);
        rd_addr = lo_nxt;
      end
      S_DUMP: begin
        res_ctrl  = '{valid: 1'b1, status: STS_LISTED, last: dump_last};
        res_value = rd_data_r;
        if (res_ready) begin
          idx_nxt = idx_r + CW'(1);
          rd_addr = idx_nxt[AW-1:0];
        end
      end
      S_RESP: begin
        res_ctrl = '{valid: 1'b1, status: status_r, last: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    val_r    <= val_nxt;
    tmp_r    <= tmp_nxt;
    flag_r   <= flag_nxt;
    status_r <= status_nxt;
  end

endmodule

@@ rtl/sorted_list_table.sv @@
// Bounded sorted list of signed values with insert, delete-first-equal, reverse and
// dump. One command beat is taken at a time. The entries live in a memory with one
// write port and one registered read port. Insert and delete walk it one entry per
// cycle; reverse swaps one pair at a time through S_REV_A, S_REV_B and S_REV_C; and a
// dump gives one result beat per cycle while the output is not stalled. A full
// insert, a delete from an empty list, a short reverse and an empty dump go straight
// to the result beat. Every command ends with a result beat carrying tlast; the
// output register lets the next command start while it waits.
// top level of the sorted list table
// depends on slt_pkg and slt_seq
module sorted_list_table
  import slt_pkg::*;
#(
  parameter int DEPTH       = SLT_DEPTH,
  parameter int VALUE_WIDTH = SLT_VALUE_WIDTH,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int IN_W  = ((2 + VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 + VALUE_WIDTH + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // op, value, zero fill
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // status, entry_value, entry_count, zero fill
  output logic             out_tlast
);

  res_ctrl_t                     res_ctrl;
  logic signed [VALUE_WIDTH-1:0] res_value;
  logic        [CW-1:0]          res_count;
  logic                          res_ready;

  logic                          out_valid_r;
  logic        [OUT_W-1:0]       out_data_r;
  logic                          out_last_r;

  slt_seq #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd_op    (op_t'(in_tdata[1:0])),
    .cmd_value (in_tdata[2 +: VALUE_WIDTH]),
    .res_ctrl  (res_ctrl),
    .res_value (res_value),
    .res_count (res_count),
    .res_ready (res_ready)
  );

  // output slot frees when empty or drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_ctrl.valid) begin
      out_data_r <= OUT_W'({res_count, res_value, res_ctrl.status});
      out_last_r <= res_ctrl.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/slt_checker.sv @@
// port-level checks of the sorted list table, bound to the top level
// depends on slt_pkg and sorted_list_table_defines.svh
`include "sorted_list_table_defines.svh"

module slt_checker
  import slt_pkg::*;
#(
  parameter int DEPTH       = SLT_DEPTH,
  parameter int VALUE_WIDTH = SLT_VALUE_WIDTH,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int IN_W  = ((2 + VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 + VALUE_WIDTH + CW + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  logic [2:0]             chk_status;
  logic [VALUE_WIDTH-1:0] chk_value;
  logic [CW-1:0]          chk_count;
  logic                   chk_in_ok;

  assign chk_status = out_tdata[2:0];
  assign chk_value  = out_tdata[3 +: VALUE_WIDTH];
  assign chk_count  = out_tdata[3 + VALUE_WIDTH +: CW];
  assign chk_in_ok  = (in_tdata[1:0] == OP_INSERT) || (in_tdata[1:0] != OP_INSERT);

  // a stalled result beat holds
  `SLT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // one command at a time: no beat taken right after another
  `SLT_ASSERT_NEXT(a_one_cmd, clk, rst_n, in_tvalid && in_tready && chk_in_ok, !in_tready)

  // only listed entries carry a value, and every other result closes its command
  `SLT_ASSERT_NOW(a_plain_result, clk, rst_n,
                  out_tvalid && (chk_status != STS_LISTED),
                  (chk_value == '0) && out_tlast)

  // held count never exceeds the table size, and a full drop reports a full table
  `SLT_ASSERT_NOW(a_count_range, clk, rst_n, out_tvalid,
                  (chk_count <= CW'(DEPTH)) &&
                  ((chk_status != STS_FULL) || (chk_count == CW'(DEPTH))))

endmodule

bind sorted_list_table slt_checker #(
  .DEPTH       (DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_slt_checker (.*);
